### rtl/pcp_pkg.sv
// ----------------------------------------------------------------------------
// pcp_pkg
// shared types, codes and the byte-wise crc-32 update for the png chunk parser
// ----------------------------------------------------------------------------
`default_nettype none

package pcp_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // register index taken from the word address
  localparam logic REG_CHUNK_LIMIT = 1'b0;

  localparam logic [15:0] CHUNK_LIMIT_RST = 16'd1000;
  localparam logic [31:0] TYPE_IEND       = 32'h49454E44;
  localparam logic [31:0] TYPE_IDAT       = 32'h49444154;
  localparam logic [31:0] CRC_POLY        = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT        = 32'hFFFFFFFF;
  localparam logic [31:0] LEFT_FIELD      = 32'd3;

  typedef enum logic [1:0] {
    KIND_LEN  = 2'd0,
    KIND_TYPE = 2'd1,
    KIND_DATA = 2'd2,
    KIND_CRC  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_RUN      = 2'd0,
    ST_BAD_CRC  = 2'd1,
    ST_TOO_MANY = 2'd2,
    ST_IEND     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    PH_LEN  = 4'b0001,
    PH_TYPE = 4'b0010,
    PH_DATA = 4'b0100,
    PH_CRC  = 4'b1000
  } phase_t;

  // one classified byte travelling from front to back
  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    kind_t       field_kind;
    logic        idat_payload;
    logic        chunk_end;
    logic [31:0] chunk_type_word;
    status_t     status;
    logic [15:0] chunks_accepted;
    logic [31:0] idat_total;
  } result_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/png_chunk_parser_crc_check_core.sv
// path: an accepted byte is written into the queue, then into the output register
// throughput: one byte per clock, sustained while out_ready stays high
// a two-entry queue between the framing front and the crc/check back end
// lets either side stall without losing a cycle
// reset (rst_n low, synchronous) clears all parser state; chunk_limit goes to 1000
// ----------------------------------------------------------------------------
// png_chunk_parser_crc_check_core
// png chunk stream parser with crc-32 check and idat byte count
// ----------------------------------------------------------------------------
`default_nettype none

module png_chunk_parser_crc_check_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [7:0]                        in_byte_in,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [7:0]                             out_byte_out,
  output logic [1:0]                             out_field_kind,
  output logic                                   out_idat_payload,
  output logic                                   out_chunk_end,
  output logic [31:0]                            out_chunk_type_word,
  output logic [1:0]                             out_status,
  output logic [15:0]                            out_chunks_accepted,
  output logic [31:0]                            out_idat_total,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [pcp_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [pcp_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [pcp_pkg::CFG_DATA_W-1:0]         prdata,
  output logic                                   pready
);
  import pcp_pkg::*;

  logic [15:0] limit_r;
  logic        reg_sel;
  logic        q_full, q_push, q_pop, q_not_empty;
  item_t       q_item, q_head;
  result_t     res;

  // register index is the word address
  assign reg_sel = (paddr[CFG_ADDR_W-1:2] == REG_CHUNK_LIMIT);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {{(CFG_DATA_W-16){1'b0}}, limit_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= CHUNK_LIMIT_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      limit_r <= pwdata[15:0];
    end
  end

  pcp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte_in (in_byte_in),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (q_item)
  );

  pcp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  pcp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .chunk_limit (limit_r),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .res         (res)
  );

  assign out_byte_out        = res.byte_out;
  assign out_field_kind      = res.field_kind;
  assign out_idat_payload    = res.idat_payload;
  assign out_chunk_end       = res.chunk_end;
  assign out_chunk_type_word = res.chunk_type_word;
  assign out_status          = res.status;
  assign out_chunks_accepted = res.chunks_accepted;
  assign out_idat_total      = res.idat_total;

endmodule

`default_nettype wire

### rtl/pcp_front.sv
// ----------------------------------------------------------------------------
// pcp_front
// frames the byte stream into length, type, data and crc fields
// ----------------------------------------------------------------------------
`default_nettype none

module pcp_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_byte_in,
  input  wire logic          q_full,
  output logic               q_push,
  output pcp_pkg::item_t     q_item
);
  import pcp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [31:0] left_r, left_nxt;
  logic [31:0] len_r, len_nxt;
  logic        last;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign last     = (left_r == 32'd0);

  always_comb begin
    phase_nxt   = phase_r;
    left_nxt    = last ? LEFT_FIELD : (left_r - 32'd1);
    len_nxt     = len_r;
    q_item.data = in_byte_in;
    q_item.last = last;
    q_item.kind = KIND_LEN;
    case (phase_r)
      PH_LEN: begin
        q_item.kind = KIND_LEN;
        len_nxt     = {len_r[23:0], in_byte_in};
        if (last) phase_nxt = PH_TYPE;
      end
      PH_TYPE: begin
        q_item.kind = KIND_TYPE;
        if (last) begin
          // empty chunk skips straight to the crc
          if (len_r == 32'd0) begin
            phase_nxt = PH_CRC;
          end else begin
            phase_nxt = PH_DATA;
            left_nxt  = len_r - 32'd1;
          end
        end
      end
      PH_DATA: begin
        q_item.kind = KIND_DATA;
        if (last) phase_nxt = PH_CRC;
      end
      PH_CRC: begin
        q_item.kind = KIND_CRC;
        if (last) phase_nxt = PH_LEN;
      end
      default: begin
        phase_nxt = PH_LEN;
        left_nxt  = LEFT_FIELD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEN;
      left_r  <= LEFT_FIELD;
      len_r   <= 32'd0;
    end else if (q_push) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/pcp_fifo.sv
// ----------------------------------------------------------------------------
// pcp_fifo
// short queue of classified bytes between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module pcp_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire pcp_pkg::item_t push_item,
  output logic               full,
  input  wire logic          pop,
  output logic               not_empty,
  output pcp_pkg::item_t     head
);
  import pcp_pkg::*;

  item_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] cnt_r;

  assign full      = (cnt_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

`default_nettype wire

### rtl/pcp_back.sv
// ----------------------------------------------------------------------------
// pcp_back
// crc update, chunk checks, counters, sticky status and the output register
// ----------------------------------------------------------------------------
`default_nettype none

module pcp_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [15:0]   chunk_limit,
  input  wire logic          q_not_empty,
  input  wire pcp_pkg::item_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output pcp_pkg::result_t   res
);
  import pcp_pkg::*;

  logic [31:0] crc_r, crc_nxt;
  logic [31:0] crc_rx_r, crc_rx_nxt;
  logic [31:0] type_r, type_nxt;
  logic [15:0] count_r, count_nxt;
  logic [31:0] idat_r, idat_nxt;
  status_t     status_r, status_nxt;
  logic        valid_r;
  result_t     res_r, res_nxt;
  logic        running;

  assign q_pop     = q_not_empty && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign res       = res_r;
  assign running   = (status_r == ST_RUN);

  always_comb begin
    crc_nxt    = crc_r;
    crc_rx_nxt = crc_rx_r;
    type_nxt   = type_r;
    count_nxt  = count_r;
    idat_nxt   = idat_r;
    status_nxt = status_r;
    res_nxt.field_kind   = KIND_LEN;
    res_nxt.idat_payload = 1'b0;
    res_nxt.chunk_end    = 1'b0;
    if (running) begin
      res_nxt.field_kind = q_head.kind;
      case (q_head.kind)
        KIND_LEN: begin
          if (q_head.last) crc_nxt = CRC_INIT;
        end
        KIND_TYPE: begin
          crc_nxt  = crc_byte(crc_r, q_head.data);
          type_nxt = {type_r[23:0], q_head.data};
        end
        KIND_DATA: begin
          crc_nxt = crc_byte(crc_r, q_head.data);
          if (type_r == TYPE_IDAT) begin
            res_nxt.idat_payload = 1'b1;
            idat_nxt             = idat_r + 32'd1;
          end
        end
        KIND_CRC: begin
          crc_rx_nxt = {crc_rx_r[23:0], q_head.data};
          if (q_head.last) begin
            res_nxt.chunk_end = 1'b1;
            // limit takes priority over the crc check
            if (count_r >= chunk_limit) begin
              status_nxt = ST_TOO_MANY;
            end else if (~crc_r != crc_rx_nxt) begin
              status_nxt = ST_BAD_CRC;
            end else begin
              count_nxt = count_r + 16'd1;
              if (type_r == TYPE_IEND) status_nxt = ST_IEND;
            end
          end
        end
        default: ;
      endcase
    end
    res_nxt.byte_out        = q_head.data;
    res_nxt.chunk_type_word = type_nxt;
    res_nxt.status          = status_nxt;
    res_nxt.chunks_accepted = count_nxt;
    res_nxt.idat_total      = idat_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r    <= CRC_INIT;
      crc_rx_r <= 32'd0;
      type_r   <= 32'd0;
      count_r  <= 16'd0;
      idat_r   <= 32'd0;
      status_r <= ST_RUN;
      valid_r  <= 1'b0;
    end else begin
      if (q_pop) begin
        crc_r    <= crc_nxt;
        crc_rx_r <= crc_rx_nxt;
        type_r   <= type_nxt;
        count_r  <= count_nxt;
        idat_r   <= idat_nxt;
        status_r <= status_nxt;
        valid_r  <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) res_r <= res_nxt;
  end

endmodule

`default_nettype wire

### rtl/pcp_checker.sv
// ----------------------------------------------------------------------------
// pcp_checker
// port-level checks on the parser's result stream, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module pcp_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [7:0]  out_byte_out,
  input  wire logic [1:0]  out_field_kind,
  input  wire logic        out_idat_payload,
  input  wire logic        out_chunk_end,
  input  wire logic [31:0] out_chunk_type_word,
  input  wire logic [1:0]  out_status
);
  import pcp_pkg::*;

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte_out) && $stable(out_status))
    else $error("result word changed while stalled");

  // chunk end only on a crc byte
  a_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_chunk_end |-> out_field_kind == KIND_CRC)
    else $error("chunk end outside crc field");

  // idat flag only on data bytes of an idat chunk
  a_idat_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_idat_payload |->
      out_field_kind == KIND_DATA && out_chunk_type_word == TYPE_IDAT)
    else $error("idat flag on a non-idat data byte");

  // once halted, words pass through untagged
  a_halt_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_RUN && !out_chunk_end |->
      out_field_kind == KIND_LEN && !out_idat_payload)
    else $error("tagged word after halt");

  // status is sticky
  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_RUN |=> !out_valid || out_status == $past(out_status))
    else $error("status changed after halt");

endmodule

bind png_chunk_parser_crc_check_core pcp_checker u_pcp_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_byte_out        (out_byte_out),
  .out_field_kind      (out_field_kind),
  .out_idat_payload    (out_idat_payload),
  .out_chunk_end       (out_chunk_end),
  .out_chunk_type_word (out_chunk_type_word),
  .out_status          (out_status)
);

`default_nettype wire
